[design/efhp_pkg.sv]
// ----------------------------------------------------------------------------
// efhp_pkg
// Shared types, constants and the crc-32 byte step for the frame header parser
// ----------------------------------------------------------------------------
package efhp_pkg;

	localparam int HEADER_BYTES = 14;
	localparam int FCS_BYTES    = 4;
	localparam int COUNT_SAT    = HEADER_BYTES + FCS_BYTES;
	localparam int COUNT_W      = $clog2(COUNT_SAT + 1);
	localparam int MAC_BYTES    = 6;

	localparam logic [15:0] ETHERTYPE_MIN = 16'd1536;
	localparam logic [15:0] ETH_IPV4      = 16'h0800;
	localparam logic [15:0] ETH_IPV6      = 16'h86DD;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int TDATA_BITS = 192;

	typedef enum logic [1:0] {
		CLS_IPV4  = 2'd0,
		CLS_IPV6  = 2'd1,
		CLS_OTHER = 2'd2
	} efhp_class_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_SHORT  = 2'd1,
		ST_NO_FCS = 2'd2
	} efhp_status_t;

	typedef struct packed {
		efhp_status_t status;
		logic [31:0]  computed_crc;
		logic [31:0]  received_crc;
		efhp_class_t  protocol_class;
		logic         is_ethertype;
		logic [15:0]  type_or_length;
		logic [47:0]  source_mac;
		logic [47:0]  dest_mac;
	} efhp_sum_t;

	typedef struct packed {
		logic      has_pay;
		logic [7:0] pay;
		logic      has_sum;
		efhp_sum_t sum;
	} efhp_entry_t;

	// tdata layout, lowest bits last in the declaration
	typedef struct packed {
		logic [2:0] pad;
		efhp_sum_t  sum;
		logic [7:0] payload_byte;
	} efhp_result_t;

	function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[design/efhp_front.sv]
// ----------------------------------------------------------------------------
// efhp_front
// Header capture, fcs delay line, crc and per-byte classification into entries
// ----------------------------------------------------------------------------
module efhp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_data,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	input  logic                 q_full,
	output logic                 in_ready,
	output logic                 push,
	output efhp_pkg::efhp_entry_t push_data
);
	import efhp_pkg::*;

	logic               fcs_q;
	logic [COUNT_W-1:0] count_q;
	logic [47:0]        dest_q;
	logic [47:0]        source_q;
	logic [15:0]        type_q;
	logic [31:0]        crc_q;
	logic [7:0]         trail_q [FCS_BYTES];

	logic               accept;
	logic [7:0]         leaving;
	logic [47:0]        dest_n;
	logic [47:0]        source_n;
	logic [15:0]        type_n;
	logic [31:0]        crc_n;
	efhp_status_t       status;
	efhp_entry_t        entry;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign leaving  = trail_q[0];

	always_comb begin
		dest_n   = dest_q;
		source_n = source_q;
		type_n   = type_q;
		if (count_q < COUNT_W'(MAC_BYTES)) begin
			dest_n = {dest_q[39:0], in_byte};
		end else if (count_q < COUNT_W'(2 * MAC_BYTES)) begin
			source_n = {source_q[39:0], in_byte};
		end else if (count_q < COUNT_W'(HEADER_BYTES)) begin
			type_n = {type_q[7:0], in_byte};
		end
		crc_n = (count_q >= COUNT_W'(FCS_BYTES)) ? crc_fold(crc_q, leaving) : crc_q;

		if (count_q < COUNT_W'(HEADER_BYTES - 1)) begin
			status = ST_SHORT;
		end else if (fcs_q && count_q < COUNT_W'(COUNT_SAT - 1)) begin
			status = ST_NO_FCS;
		end else begin
			status = ST_OK;
		end

		entry = '0;
		if (fcs_q) begin
			entry.has_pay = count_q >= COUNT_W'(COUNT_SAT);
			entry.pay     = leaving;
		end else begin
			entry.has_pay = count_q >= COUNT_W'(HEADER_BYTES);
			entry.pay     = in_byte;
		end
		if (!entry.has_pay) begin
			entry.pay = 8'd0;
		end
		entry.has_sum            = in_last;
		entry.sum.status         = status;
		entry.sum.computed_crc   = crc_n ^ CRC_INIT;
		entry.sum.protocol_class = CLS_OTHER;
		if (status != ST_SHORT) begin
			entry.sum.dest_mac       = dest_n;
			entry.sum.source_mac     = source_n;
			entry.sum.type_or_length = type_n;
			entry.sum.is_ethertype   = type_n >= ETHERTYPE_MIN;
			if (type_n == ETH_IPV4) begin
				entry.sum.protocol_class = CLS_IPV4;
			end else if (type_n == ETH_IPV6) begin
				entry.sum.protocol_class = CLS_IPV6;
			end
		end
		if (status == ST_OK && fcs_q) begin
			entry.sum.received_crc = {trail_q[1], trail_q[2], trail_q[3], in_byte};
		end
	end

	assign push      = accept && (entry.has_pay || entry.has_sum);
	assign push_data = entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcs_q <= 1'b1;
		end else if (cfg_valid) begin
			fcs_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			dest_q   <= '0;
			source_q <= '0;
			type_q   <= '0;
			crc_q    <= CRC_INIT;
			for (int i = 0; i < FCS_BYTES; i++) begin
				trail_q[i] <= '0;
			end
		end else if (accept) begin
			if (in_last) begin
				count_q  <= '0;
				dest_q   <= '0;
				source_q <= '0;
				type_q   <= '0;
				crc_q    <= CRC_INIT;
				for (int i = 0; i < FCS_BYTES; i++) begin
					trail_q[i] <= '0;
				end
			end else begin
				if (count_q < COUNT_W'(COUNT_SAT)) begin
					count_q <= count_q + COUNT_W'(1);
				end
				dest_q   <= dest_n;
				source_q <= source_n;
				type_q   <= type_n;
				crc_q    <= crc_n;
				for (int i = 0; i < FCS_BYTES - 1; i++) begin
					trail_q[i] <= trail_q[i + 1];
				end
				trail_q[FCS_BYTES - 1] <= in_byte;
			end
		end
	end

endmodule

[design/efhp_queue.sv]
// ----------------------------------------------------------------------------
// efhp_queue
// Short first-in first-out queue of entries between front and back
// ----------------------------------------------------------------------------
module efhp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  efhp_pkg::efhp_entry_t push_data,
	input  logic                  pop,
	output efhp_pkg::efhp_entry_t pop_data,
	output logic                  full,
	output logic                  empty
);
	import efhp_pkg::*;

	efhp_entry_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full     = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

[design/efhp_back.sv]
// ----------------------------------------------------------------------------
// efhp_back
// Splits each entry into payload and summary results on a registered output
// ----------------------------------------------------------------------------
module efhp_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  efhp_pkg::efhp_entry_t             head,
	input  logic                              empty,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [efhp_pkg::TDATA_BITS-1:0]   out_data,
	output logic                              out_kind,
	output logic                              out_last
);
	import efhp_pkg::*;

	logic         phase_q;
	logic         tvalid_q;
	logic         tuser_q;
	logic         tlast_q;
	efhp_result_t tdata_q;

	logic         load;
	logic         emit_pay;
	efhp_result_t res;

	assign load     = !tvalid_q || out_ready;
	assign emit_pay = head.has_pay && !phase_q;
	assign pop      = load && !empty && !(emit_pay && head.has_sum);

	always_comb begin
		res = '0;
		if (emit_pay) begin
			res.payload_byte = head.pay;
		end else begin
			res.sum = head.sum;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			tdata_q <= res;
			tuser_q <= emit_pay ? KIND_PAYLOAD : KIND_SUMMARY;
			tlast_q <= !(emit_pay && head.has_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
			phase_q  <= 1'b0;
		end else if (load) begin
			tvalid_q <= !empty;
			if (!empty) begin
				phase_q <= emit_pay && head.has_sum;
			end
		end
	end

	assign out_valid = tvalid_q;
	assign out_data  = tdata_q;
	assign out_kind  = tuser_q;
	assign out_last  = tlast_q;

endmodule

[design/ethernet_frame_header_parser.sv]
// ----------------------------------------------------------------------------
// ethernet_frame_header_parser
// Ethernet II header parser with fcs strip and crc-32 check value
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle, back to back, with tlast on the final byte.
// Each byte is classified and its header, delay-line and crc state updated in
// the cycle it is taken; its results reach the master side through a
// four-entry queue and an output register. A frame end yields a payload byte
// (when one is due) and a summary as separate results; the slave side stalls
// only when the queue fills behind a stalled master side.
// The one-bit fcs_present register is written through cfg_valid/cfg_data,
// always ready, and should only change between frames.
module ethernet_frame_header_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_data,   // fcs_present
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,    // data_byte
	input  logic                            s_tlast,    // last_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// payload_byte, dest_mac, source_mac, type_or_length, is_ethertype,
	// protocol_class, received_crc, computed_crc, frame_status, zero pad
	output logic [efhp_pkg::TDATA_BITS-1:0] m_tdata,
	output logic                            m_tuser,    // kind_out
	output logic                            m_tlast     // end_of_run
);
	import efhp_pkg::*;

	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_empty;
	efhp_entry_t push_data;
	efhp_entry_t head;

	assign cfg_ready = 1'b1;

	efhp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.q_full    (q_full),
		.in_ready  (s_tready),
		.push      (push),
		.push_data (push_data)
	);

	efhp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	efhp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

[design/efhp_checker.sv]
// ----------------------------------------------------------------------------
// efhp_checker
// Port-level checks on the result stream of the frame header parser
// ----------------------------------------------------------------------------
module efhp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [efhp_pkg::TDATA_BITS-1:0] m_tdata,
	input logic                            m_tuser,
	input logic                            m_tlast
);
	import efhp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed under stall");

	a_pay_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PAYLOAD |-> m_tdata[TDATA_BITS-1:8] == '0)
		else $error("payload result carries summary bits");

	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_SUMMARY |-> m_tlast && m_tdata[7:0] == 8'd0)
		else $error("summary not the last result or has a payload byte");

	a_ipv4_type: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_SUMMARY && m_tdata[122:121] == CLS_IPV4
		|-> m_tdata[119:104] == ETH_IPV4)
		else $error("ipv4 class without ipv4 type");

endmodule

bind ethernet_frame_header_parser efhp_checker u_efhp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[tb/sv/ethernet_frame_header_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_frame_header_parser_tb
// Self-checking bench for the byte-stream ethernet header parser
// ----------------------------------------------------------------------------
// Frames go in one byte per request and every byte is run through a cycle-free
// copy of the parser (header capture, trailer window, crc-32), which queues the
// payload bytes and frame summaries that the block must return. Each result on
// the master side is checked field by field against the oldest queued one.
// Directed frames cover short frames, frames without room for the fcs, both
// fcs settings, every protocol class and a setting change inside a frame; then
// random frames run under several sender/receiver idling mixes, and one long
// receiver hold fills the block and stalls its input.
// ----------------------------------------------------------------------------
module ethernet_frame_header_parser_tb;

	import efhp_pkg::*;

	localparam int FILL_RANDOM  = 0;
	localparam int FILL_ZERO    = 1;
	localparam int FILL_ONES    = 2;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_BYTES = 800;

	typedef struct {
		logic       kind;
		logic [7:0] pay;
		efhp_sum_t  sum;
		logic       eor;
	} frame_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_data  = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = 8'd0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [TDATA_BITS-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	// parser copy
	logic        fcs_on;
	logic [4:0]  byte_pos;
	logic [47:0] dest_acc;
	logic [47:0] src_acc;
	logic [15:0] type_acc;
	logic [31:0] crc_acc;
	logic [7:0]  fcs_window [FCS_BYTES];

	frame_result_t pending_frame_results [$];

	int err_count  = 0;
	int bytes_sent = 0;
	int idle_pct   = 0;
	int stall_pct  = 0;
	int hold_reqs  = 0;
	int hold_seen  = 0;
	int hold_left  = 0;

	ethernet_frame_header_parser uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] d);
		logic [31:0] r;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ ((r[0] ^ d[k]) ? CRC_POLY : 32'd0);
		end
		return r;
	endfunction

	task automatic clear_frame_state();
		byte_pos = '0;
		dest_acc = '0;
		src_acc  = '0;
		type_acc = '0;
		crc_acc  = CRC_INIT;
		for (int k = 0; k < FCS_BYTES; k++) begin
			fcs_window[k] = 8'd0;
		end
	endtask

	task automatic predict_frame_byte(input logic [7:0] b, input logic last);
		logic [4:0]    pos;
		logic [7:0]    leaving;
		logic          has_pay;
		efhp_status_t  st;
		frame_result_t pay_r;
		frame_result_t sum_r;
		pos     = byte_pos;
		leaving = fcs_window[0];
		has_pay = 1'b0;
		pay_r.pay = 8'd0;
		if (pos < MAC_BYTES) begin
			dest_acc = {dest_acc[39:0], b};
		end else if (pos < 2 * MAC_BYTES) begin
			src_acc = {src_acc[39:0], b};
		end else if (pos < HEADER_BYTES) begin
			type_acc = {type_acc[7:0], b};
		end
		if (pos >= FCS_BYTES) begin
			crc_acc = crc32_step(crc_acc, leaving);
		end
		for (int k = 0; k < FCS_BYTES - 1; k++) begin
			fcs_window[k] = fcs_window[k + 1];
		end
		fcs_window[FCS_BYTES - 1] = b;
		if (fcs_on) begin
			if (pos >= COUNT_SAT) begin
				has_pay   = 1'b1;
				pay_r.pay = leaving;
			end
		end else if (pos >= HEADER_BYTES) begin
			has_pay   = 1'b1;
			pay_r.pay = b;
		end
		if (byte_pos < COUNT_SAT) begin
			byte_pos = byte_pos + 5'd1;
		end
		if (has_pay) begin
			pay_r.kind = KIND_PAYLOAD;
			pay_r.sum  = '0;
			pay_r.eor  = !last;
			pending_frame_results.push_back(pay_r);
		end
		if (last) begin
			if (pos + 1 < HEADER_BYTES) begin
				st = ST_SHORT;
			end else if (fcs_on && pos + 1 < COUNT_SAT) begin
				st = ST_NO_FCS;
			end else begin
				st = ST_OK;
			end
			sum_r.kind = KIND_SUMMARY;
			sum_r.pay  = 8'd0;
			sum_r.eor  = 1'b1;
			sum_r.sum  = '0;
			sum_r.sum.protocol_class = CLS_OTHER;
			if (st != ST_SHORT) begin
				sum_r.sum.dest_mac       = dest_acc;
				sum_r.sum.source_mac     = src_acc;
				sum_r.sum.type_or_length = type_acc;
				sum_r.sum.is_ethertype   = (type_acc >= ETHERTYPE_MIN);
				if (type_acc == ETH_IPV4) begin
					sum_r.sum.protocol_class = CLS_IPV4;
				end else if (type_acc == ETH_IPV6) begin
					sum_r.sum.protocol_class = CLS_IPV6;
				end
			end
			if (st == ST_OK && fcs_on) begin
				sum_r.sum.received_crc = {fcs_window[0], fcs_window[1],
				                          fcs_window[2], fcs_window[3]};
			end
			sum_r.sum.computed_crc = ~crc_acc;
			sum_r.sum.status       = st;
			pending_frame_results.push_back(sum_r);
			clear_frame_state();
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
		if (exp !== act) begin
			$display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp, act);
			err_count++;
		end
	endtask

	// result checker and receiver ready
	always @(posedge clk) begin
		efhp_result_t  got;
		frame_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending_frame_results.size() == 0) begin
					$display("%0t mismatch result: expected none, actual %0h", $time, m_tdata);
					err_count++;
				end else begin
					want = pending_frame_results.pop_front();
					check_field("kind_out", 64'(want.kind), 64'(m_tuser));
					check_field("payload_byte", 64'(want.pay), 64'(got.payload_byte));
					check_field("dest_mac", 64'(want.sum.dest_mac), 64'(got.sum.dest_mac));
					check_field("source_mac", 64'(want.sum.source_mac),
					            64'(got.sum.source_mac));
					check_field("type_or_length", 64'(want.sum.type_or_length),
					            64'(got.sum.type_or_length));
					check_field("is_ethertype", 64'(want.sum.is_ethertype),
					            64'(got.sum.is_ethertype));
					check_field("protocol_class", 64'(want.sum.protocol_class),
					            64'(got.sum.protocol_class));
					check_field("received_crc", 64'(want.sum.received_crc),
					            64'(got.sum.received_crc));
					check_field("computed_crc", 64'(want.sum.computed_crc),
					            64'(got.sum.computed_crc));
					check_field("frame_status", 64'(want.sum.status), 64'(got.sum.status));
					check_field("end_of_run", 64'(want.eor), 64'(m_tlast));
				end
			end
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		predict_frame_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_frame(input int len, input logic [15:0] tword, input int fill,
	                          input logic close);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			if (i == HEADER_BYTES - 2) begin
				b = tword[15:8];
			end else if (i == HEADER_BYTES - 1) begin
				b = tword[7:0];
			end else if (fill == FILL_ZERO) begin
				b = 8'h00;
			end else if (fill == FILL_ONES) begin
				b = 8'hFF;
			end else begin
				b = 8'($urandom_range(255));
			end
			send_byte(b, close && (i == len - 1));
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_frame_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_fcs(input logic v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		fcs_on = v;
	endtask

	function automatic int pick_frame_len();
		int r;
		r = $urandom_range(99);
		if (r < 12) begin
			return $urandom_range(1, HEADER_BYTES - 1);
		end else if (r < 22) begin
			return $urandom_range(HEADER_BYTES, COUNT_SAT - 1);
		end else if (r < 92) begin
			return $urandom_range(COUNT_SAT, 40);
		end
		return $urandom_range(41, 80);
	endfunction

	function automatic logic [15:0] pick_type_word();
		case ($urandom_range(7))
			0: return ETH_IPV4;
			1: return ETH_IPV6;
			2: return ETHERTYPE_MIN - 16'd1;
			3: return ETHERTYPE_MIN;
			4: return 16'h0000;
			5: return 16'hFFFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	task automatic test_short_frames();
		send_frame(1, 16'h0000, FILL_RANDOM, 1'b1);
		send_frame(HEADER_BYTES - 1, ETH_IPV4, FILL_ZERO, 1'b1);
	endtask

	task automatic test_missing_fcs_room();
		send_frame(16, ETH_IPV4, FILL_RANDOM, 1'b1);
		send_frame(COUNT_SAT - 1, 16'hFFFF, FILL_ONES, 1'b1);
	endtask

	task automatic test_fcs_stripped();
		send_frame(COUNT_SAT + 1, ETH_IPV6, FILL_ONES, 1'b1);
		send_frame(COUNT_SAT, ETHERTYPE_MIN - 16'd1, FILL_ZERO, 1'b1);
	endtask

	task automatic test_fcs_absent();
		write_fcs(1'b0);
		send_frame(HEADER_BYTES + 1, ETHERTYPE_MIN, FILL_RANDOM, 1'b1);
		send_frame(HEADER_BYTES, 16'h0000, FILL_ZERO, 1'b1);
		send_frame(3, 16'h0000, FILL_RANDOM, 1'b1);
	endtask

	task automatic test_config_mid_frame();
		write_fcs(1'b0);
		send_frame(16, ETH_IPV4, FILL_RANDOM, 1'b0);
		write_fcs(1'b1);
		for (int i = 0; i < 6; i++) begin
			send_byte(8'($urandom_range(255)), i == 5);
		end
		write_fcs(1'b0);
		send_frame(COUNT_SAT + 2, ETH_IPV6, FILL_RANDOM, 1'b0);
		write_fcs(1'b1);
		send_frame(2, 16'h0000, FILL_RANDOM, 1'b1);
	endtask

	task automatic test_backpressure();
		write_fcs(1'b1);
		idle_pct  = 0;
		stall_pct = 0;
		hold_reqs++;
		for (int f = 0; f < 8; f++) begin
			send_frame($urandom_range(COUNT_SAT + 4, 30), pick_type_word(), FILL_RANDOM, 1'b1);
		end
	endtask

	task automatic test_random_traffic();
		int idle_mix  [4] = '{0, 83, 0, 38};
		int stall_mix [4] = '{0, 0, 83, 38};
		int stop_at;
		for (int p = 0; p < 8; p++) begin
			write_fcs(p[0] == 1'b0);
			idle_pct  = idle_mix[p % 4];
			stall_pct = stall_mix[p % 4];
			stop_at   = bytes_sent + RANDOM_BYTES / 8;
			while (bytes_sent < stop_at) begin
				send_frame(pick_frame_len(), pick_type_word(), FILL_RANDOM, 1'b1);
			end
		end
	endtask

	initial begin
		fcs_on = 1'b1;
		clear_frame_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_frames();
		test_missing_fcs_room();
		test_fcs_stripped();
		test_fcs_absent();
		test_config_mid_frame();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
